// ===== sv/hpts_pkg.sv =====
// ----------------------------------------------------------------------------
// hpts_pkg
// Shared types, constants and helpers for the hex pattern trigger sequencer.
// ----------------------------------------------------------------------------
package hpts_pkg;

    localparam int TRACKS      = 16;
    localparam int PATTERNS    = 128;
    localparam int MAX_NIBBLES = 16;
    localparam int TRK_W       = $clog2(TRACKS);
    localparam int PAT_W       = $clog2(PATTERNS);
    localparam int ADDR_W      = PAT_W + TRK_W;
    localparam int DEPTH       = PATTERNS * TRACKS;

    localparam logic [31:0] LFSR_TAPS    = 32'h8020_0003;
    localparam logic [15:0] PULSE_RESET  = 16'd480;
    localparam logic [31:0] SEED_RESET   = 32'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PAT   = 2'd1,
        OP_TRACK = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_DELAY = 2'd0,
        CFG_PULSE = 2'd1,
        CFG_SEED  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_TICK,
        ST_READ,
        ST_WAIT,
        ST_EVAL,
        ST_PULSE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             clear_wr;
        logic             capture;
        logic             do_write;
        logic             tick_prep;
        logic             rd_issue;
        logic             eval;
        logic             pulse;
        logic             step_done;
        logic             out_load;
        logic [TRK_W-1:0] trk;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic do_step;
    } stat_t;

    function automatic logic [31:0] lfsr_advance(input logic [31:0] v);
        logic [31:0] s;
        s = {1'b0, v[31:1]};
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// ===== sv/hpts_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpts_ctrl
// Sequencer controller: clear pass, writes, and per-track step walk.
// ----------------------------------------------------------------------------
module hpts_ctrl
    import hpts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        cmd.trk    = cnt_reg[TRK_W-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (stat.is_tick)
                begin
                    state_next = ST_TICK;
                end
                else
                begin
                    cmd.do_write = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_TICK:
            begin
                cmd.tick_prep = 1'b1;
                cnt_next      = '0;
                state_next    = ST_PULSE;
                if (stat.do_step)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                state_next = ST_READ;
                if (cnt_reg[TRK_W-1:0] == TRK_W'(TRACKS - 1))
                begin
                    cmd.step_done = 1'b1;
                    state_next    = ST_PULSE;
                end
            end
            ST_PULSE:
            begin
                cmd.pulse  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_load = 1'b1;
                ov_next      = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/hpts_dp.sv =====
// ----------------------------------------------------------------------------
// hpts_dp
// Sequencer datapath: pattern store, track settings, LFSR, pulse counters.
// ----------------------------------------------------------------------------
module hpts_dp
    import hpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  op,
    input  logic        clock_edge,
    input  logic        reset_edge,
    input  logic [6:0]  pattern_select,
    input  logic [3:0]  track,
    input  logic [6:0]  pattern_index,
    input  logic [63:0] nibbles,
    input  logic [4:0]  length,
    input  logic [15:0] wild_mask,
    input  logic [9:0]  main_prob,
    input  logic [8:0]  inv_prob,
    input  logic        enable,
    output logic [15:0] trig_mask,
    output logic [15:0] gate_mask,
    output logic [15:0] inv_trig_mask,
    output logic        stepped
);

    logic [63:0] nib_mem [DEPTH];
    logic [4:0]  len_mem [DEPTH];
    logic [15:0] wild_mem [DEPTH];
    logic [63:0] nib_rd;
    logic [4:0]  len_rd;
    logic [15:0] wild_rd;

    logic [3:0]  delay_cfg_reg;
    logic [15:0] pulse_cfg_reg;
    logic [31:0] lfsr_reg, lfsr_next;

    logic [1:0]  op_reg;
    logic        ce_reg, re_reg;
    logic [6:0]  sel_reg;
    logic [3:0]  trk_in_reg;
    logic [6:0]  pidx_reg;
    logic [63:0] nib_in_reg;
    logic [4:0]  len_in_reg;
    logic [15:0] wild_in_reg;
    logic [9:0]  mp_in_reg;
    logic [8:0]  ip_in_reg;
    logic        en_in_reg;

    logic [9:0]  mp_reg [TRACKS];
    logic [8:0]  ip_reg [TRACKS];
    logic [TRACKS-1:0] en_reg;
    logic [31:0] pos_reg;
    logic [PAT_W-1:0] cur_reg;
    logic [3:0]  dcnt_reg;
    logic        dpend_reg;
    logic        step_reg;
    logic [TRACKS-1:0] gate_reg;
    logic [15:0] trem_reg [TRACKS];
    logic [15:0] irem_reg [TRACKS];
    logic [15:0] trig_o_reg, gate_o_reg, inv_o_reg;
    logic        stepped_o_reg;
    logic [15:0] trig_mask_n, inv_mask_n;

    // position residues per length, kept per step:
    // pos_mod[L] tracks step_position mod 4L for every length from 1 to 15.
    logic [5:0] pos_mod [MAX_NIBBLES];

    logic [PAT_W-1:0] sel_sat;
    logic [3:0]  dcnt_a;
    logic        dpend_a;
    logic        pat_wr_ok;

    assign sel_sat = ({1'b0, sel_reg} >= 8'(PATTERNS)) ? PAT_W'(PATTERNS - 1)
                                                       : sel_reg[PAT_W-1:0];
    assign pat_wr_ok = cmd.do_write && (op_reg == OP_PAT)
                       && ({1'b0, pidx_reg} < 8'(PATTERNS));

    always_comb
    begin
        dcnt_a  = dcnt_reg;
        dpend_a = dpend_reg;
        if (ce_reg)
        begin
            dpend_a = 1'b1;
            dcnt_a  = delay_cfg_reg;
        end
        if (dpend_a && dcnt_a != 4'd0)
        begin
            dcnt_a = dcnt_a - 4'd1;
        end
    end

    assign stat.is_tick = (op_reg == OP_TICK);
    assign stat.do_step = dpend_a && (dcnt_a == 4'd0);

    logic [ADDR_W-1:0] wr_addr, rd_addr;
    assign wr_addr = {pidx_reg[PAT_W-1:0], trk_in_reg[TRK_W-1:0]};
    assign rd_addr = {cur_reg, cmd.trk};

    always_ff @(posedge clk)
    begin
        if (pat_wr_ok)
        begin
            nib_mem[wr_addr]  <= nib_in_reg;
            wild_mem[wr_addr] <= wild_in_reg;
        end
        if (cmd.rd_issue)
        begin
            nib_rd  <= nib_mem[rd_addr];
            wild_rd <= wild_mem[rd_addr];
        end
    end

    // clear pass address comes from a dedicated counter
    logic [ADDR_W-1:0] clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            len_mem[clr_reg] <= 5'd0;
        end
        else if (pat_wr_ok)
        begin
            len_mem[wr_addr] <= len_in_reg;
        end
        if (cmd.rd_issue)
        begin
            len_rd <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            ce_reg      <= clock_edge;
            re_reg      <= reset_edge;
            sel_reg     <= pattern_select;
            trk_in_reg  <= track;
            pidx_reg    <= pattern_index;
            nib_in_reg  <= nibbles;
            len_in_reg  <= length;
            wild_in_reg <= wild_mask;
            mp_in_reg   <= main_prob;
            ip_in_reg   <= inv_prob;
            en_in_reg   <= enable;
        end
        // hold the pulse state seen before the tick's count down
        if (cmd.pulse)
        begin
            trig_o_reg <= trig_mask_n;
            inv_o_reg  <= inv_mask_n;
        end
        if (cmd.out_load)
        begin
            if (op_reg != OP_TICK)
            begin
                trig_o_reg <= trig_mask_n;
                inv_o_reg  <= inv_mask_n;
            end
            gate_o_reg    <= gate_reg;
            stepped_o_reg <= step_reg && (op_reg == OP_TICK);
        end
    end

    always_comb
    begin
        trig_mask_n = '0;
        inv_mask_n  = '0;
        for (int k = 0; k < TRACKS; k++)
        begin
            trig_mask_n[k] = (trem_reg[k] != 16'd0);
            inv_mask_n[k]  = (irem_reg[k] != 16'd0);
        end
    end

    // evaluation of one track
    logic [4:0]  len_c;
    logic [6:0]  modv;
    logic [5:0]  spos;
    logic [3:0]  cpos;
    logic        wild;
    logic [31:0] l1, l2, l3;
    logic [3:0]  nib;
    logic        on;
    logic [9:0]  mp;
    logic [8:0]  ip;
    logic        fire, inv, m_coin, i_coin;
    logic [31:0] lf;

    always_comb
    begin
        len_c = (len_rd > 5'(MAX_NIBBLES)) ? 5'(MAX_NIBBLES) : len_rd;
        modv  = {len_c, 2'b00};
        spos  = '0;
        case (len_c)
            5'd1:  spos = {4'd0, pos_reg[1:0]};
            5'd2:  spos = {3'd0, pos_reg[2:0]};
            5'd4:  spos = {2'd0, pos_reg[3:0]};
            5'd8:  spos = {1'd0, pos_reg[4:0]};
            5'd16: spos = pos_reg[5:0];
            default: spos = 6'(pos_mod[len_c[3:0]]);
        endcase
        cpos = spos[5:2];
        wild = wild_rd[cpos];
        lf   = lfsr_reg;
        l1   = lfsr_advance(lf);
        if (wild)
        begin
            nib = l1[3:0];
            lf  = l1;
        end
        else
        begin
            nib = nib_rd[6'd60 - {cpos, 2'b00} +: 4];
        end
        on = nib[2'd3 - spos[1:0]];
        mp = (mp_reg[cmd.trk] > 10'd512) ? 10'd512 : mp_reg[cmd.trk];
        ip = (ip_reg[cmd.trk] > 9'd256) ? 9'd256 : ip_reg[cmd.trk];
        l2 = lfsr_advance(lf);
        fire = 1'b0;
        m_coin = 1'b0;
        if (en_reg[cmd.trk])
        begin
            if (mp == 10'd256)
            begin
                fire = on;
            end
            else if (mp < 10'd256)
            begin
                if (on)
                begin
                    m_coin = 1'b1;
                    fire   = ({2'b00, l2[7:0]} < mp);
                end
            end
            else if (on)
            begin
                fire = 1'b1;
            end
            else
            begin
                m_coin = 1'b1;
                fire   = ({2'b00, l2[7:0]} < (mp - 10'd256));
            end
        end
        if (m_coin)
        begin
            lf = l2;
        end
        l3 = lfsr_advance(lf);
        inv = 1'b0;
        i_coin = 1'b0;
        if (!fire && en_reg[cmd.trk])
        begin
            if (ip == 9'd256)
            begin
                inv = !on;
            end
            else if (!on)
            begin
                i_coin = 1'b1;
                inv    = ({1'b0, l3[7:0]} < ip);
            end
        end
        if (i_coin)
        begin
            lf = l3;
        end
        lfsr_next = lf;
        if (modv == 7'd0)
        begin
            lfsr_next = lfsr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg_reg <= 4'd0;
            pulse_cfg_reg <= PULSE_RESET;
            lfsr_reg      <= SEED_RESET;
            en_reg        <= '1;
            pos_reg       <= '0;
            cur_reg       <= '0;
            dcnt_reg      <= '0;
            dpend_reg     <= 1'b0;
            step_reg      <= 1'b0;
            gate_reg      <= '0;
            for (int k = 0; k < TRACKS; k++)
            begin
                mp_reg[k]   <= 10'd256;
                ip_reg[k]   <= 9'd256;
                trem_reg[k] <= '0;
                irem_reg[k] <= '0;
            end
            for (int l = 0; l < MAX_NIBBLES; l++)
            begin
                pos_mod[l] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DELAY: delay_cfg_reg <= cfg_data[3:0];
                    CFG_PULSE: pulse_cfg_reg <= cfg_data[15:0];
                    CFG_SEED:  lfsr_reg <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.capture)
            begin
                step_reg <= 1'b0;
            end
            if (cmd.do_write && op_reg == OP_TRACK)
            begin
                mp_reg[trk_in_reg[TRK_W-1:0]] <= mp_in_reg;
                ip_reg[trk_in_reg[TRK_W-1:0]] <= ip_in_reg;
                en_reg[trk_in_reg[TRK_W-1:0]] <= en_in_reg;
            end
            if (cmd.tick_prep)
            begin
                if (re_reg || sel_sat != cur_reg)
                begin
                    pos_reg <= '0;
                    for (int l = 0; l < MAX_NIBBLES; l++)
                    begin
                        pos_mod[l] <= '0;
                    end
                end
                cur_reg   <= sel_sat;
                dcnt_reg  <= dcnt_a;
                dpend_reg <= dpend_a && !stat.do_step;
                step_reg  <= stat.do_step;
            end
            if (cmd.eval && modv != 7'd0)
            begin
                lfsr_reg <= lfsr_next;
                if (fire)
                begin
                    gate_reg[cmd.trk] <= 1'b1;
                    if (pulse_cfg_reg > trem_reg[cmd.trk])
                    begin
                        trem_reg[cmd.trk] <= pulse_cfg_reg;
                    end
                end
                else
                begin
                    gate_reg[cmd.trk] <= 1'b0;
                    if (inv && pulse_cfg_reg > irem_reg[cmd.trk])
                    begin
                        irem_reg[cmd.trk] <= pulse_cfg_reg;
                    end
                end
            end
            if (cmd.step_done)
            begin
                pos_reg <= pos_reg + 32'd1;
                // wrap each residue at 4L, and restart every residue when the position wraps
                for (int l = 1; l < MAX_NIBBLES; l++)
                begin
                    if (pos_reg == 32'hFFFF_FFFF || pos_mod[l] == 6'(4 * l - 1))
                    begin
                        pos_mod[l] <= '0;
                    end
                    else
                    begin
                        pos_mod[l] <= pos_mod[l] + 6'd1;
                    end
                end
            end
            if (cmd.pulse)
            begin
                for (int k = 0; k < TRACKS; k++)
                begin
                    if (trem_reg[k] != 16'd0)
                    begin
                        trem_reg[k] <= trem_reg[k] - 16'd1;
                    end
                    if (irem_reg[k] != 16'd0)
                    begin
                        irem_reg[k] <= irem_reg[k] - 16'd1;
                    end
                end
            end
        end
    end

    assign trig_mask     = trig_o_reg;
    assign gate_mask     = gate_o_reg;
    assign inv_trig_mask = inv_o_reg;
    assign stepped       = stepped_o_reg;

endmodule

// ===== sv/hex_pattern_trigger_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// hex_pattern_trigger_sequencer_core
// Sixteen-track hex pattern trigger sequencer, top level.
// ----------------------------------------------------------------------------
// channel  | handshake             | contents
// in       | in_valid / in_stall   | op, edges, select, write fields
// out      | out_valid / out_stall | trig_mask, gate_mask, inv_trig_mask, stepped
// cfg      | cfg_we                | cfg_index, cfg_data
// A write passes through the write and output states after the input transfer; a
// tick through the tick, pulse and output states, and a stepping tick also through
// one pattern memory read, wait and evaluation per track in turn. The next input
// transfer is taken only once the result has been taken from the output.
// After reset a clear pass zeroes all 2048 entries of the length store; no transfer
// is taken during it. A result waits in the output register while stalled.
// ----------------------------------------------------------------------------
module hex_pattern_trigger_sequencer_core
    import hpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic        clock_edge,
    input  logic        reset_edge,
    input  logic [6:0]  pattern_select,
    input  logic [3:0]  track,
    input  logic [6:0]  pattern_index,
    input  logic [63:0] nibbles,
    input  logic [4:0]  length,
    input  logic [15:0] wild_mask,
    input  logic [9:0]  main_prob,
    input  logic [8:0]  inv_prob,
    input  logic        enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] trig_mask,
    output logic [15:0] gate_mask,
    output logic [15:0] inv_trig_mask,
    output logic        stepped,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    hpts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hpts_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .clock_edge     (clock_edge),
        .reset_edge     (reset_edge),
        .pattern_select (pattern_select),
        .track          (track),
        .pattern_index  (pattern_index),
        .nibbles        (nibbles),
        .length         (length),
        .wild_mask      (wild_mask),
        .main_prob      (main_prob),
        .inv_prob       (inv_prob),
        .enable         (enable),
        .trig_mask      (trig_mask),
        .gate_mask      (gate_mask),
        .inv_trig_mask  (inv_trig_mask),
        .stepped        (stepped)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result not presented");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.eval, cmd.pulse, cmd.out_load}))
        else $error("conflicting commands");
`endif

endmodule

// ===== dv/hpts_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpts_checker
// Watches the input, output and register channels of the hex pattern trigger
// sequencer, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module hpts_checker
    import hpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic        clock_edge,
    input  logic        reset_edge,
    input  logic [6:0]  pattern_select,
    input  logic [3:0]  track,
    input  logic [6:0]  pattern_index,
    input  logic [63:0] nibbles,
    input  logic [4:0]  length,
    input  logic [15:0] wild_mask,
    input  logic [9:0]  main_prob,
    input  logic [8:0]  inv_prob,
    input  logic        enable,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] trig_mask,
    input  logic [15:0] gate_mask,
    input  logic [15:0] inv_trig_mask,
    input  logic        stepped,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] trig;
        logic [15:0] gate;
        logic [15:0] inv;
        logic        stp;
    } seq_out_t;

    seq_out_t    expected_q[$];

    logic [3:0]  delay_cfg;
    logic [15:0] pulse_cfg;
    logic [63:0] nib_mem [DEPTH];
    logic [4:0]  len_mem [DEPTH];
    logic [15:0] wild_mem [DEPTH];
    logic [9:0]  mprob [TRACKS];
    logic [8:0]  iprob [TRACKS];
    logic        en_bits [TRACKS];
    logic [31:0] position;
    logic [6:0]  cur_pat;
    logic [3:0]  dly_cnt;
    logic        dly_pend;
    logic [15:0] gates;
    logic [15:0] trig_left [TRACKS];
    logic [15:0] inv_left [TRACKS];
    logic [31:0] lfsr;

    function automatic logic [31:0] rand_draw();
        logic low;
        low  = lfsr[0];
        lfsr = {1'b0, lfsr[31:1]};
        if (low)
        begin
            lfsr = lfsr ^ 32'h8020_0003;
        end
        return lfsr;
    endfunction

    function automatic logic flip(input int p);
        logic [31:0] r;
        r = rand_draw();
        return int'(r[7:0]) < p;
    endfunction

    function automatic void advance_step();
        int idx, len, spos, cpos, mp, ip;
        logic [3:0] nib;
        logic on, fire, inv;
        for (int k = 0; k < TRACKS; k++)
        begin
            idx = int'(cur_pat) * TRACKS + k;
            len = int'(len_mem[idx]);
            if (len > MAX_NIBBLES) len = MAX_NIBBLES;
            if (len == 0) continue;
            spos = int'(position % (len * 4));
            cpos = (spos >> 2) & 15;
            if (wild_mem[idx][cpos]) nib = 4'(rand_draw());
            else nib = nib_mem[idx][60 - 4 * cpos +: 4];
            on = nib[3 - (spos & 3)];
            mp = int'(mprob[k]);
            if (mp > 512) mp = 512;
            ip = int'(iprob[k]);
            if (ip > 256) ip = 256;
            fire = 1'b0;
            if (en_bits[k])
            begin
                if (mp == 256) fire = on;
                else if (mp < 256) fire = on ? flip(mp) : 1'b0;
                else fire = on ? 1'b1 : flip(mp - 256);
            end
            if (fire)
            begin
                if (pulse_cfg > trig_left[k]) trig_left[k] = pulse_cfg;
                gates[k] = 1'b1;
            end
            else
            begin
                gates[k] = 1'b0;
                inv = 1'b0;
                if (en_bits[k])
                begin
                    if (ip == 256) inv = !on;
                    else if (!on) inv = flip(ip);
                end
                if (inv && pulse_cfg > inv_left[k]) inv_left[k] = pulse_cfg;
            end
        end
        position++;
    endfunction

    function automatic seq_out_t predict_transfer();
        seq_out_t r;
        r = '0;
        if (op == OP_TICK)
        begin
            if (reset_edge) position = 0;
            if (pattern_select != cur_pat)
            begin
                cur_pat  = pattern_select;
                position = 0;
            end
            if (clock_edge)
            begin
                dly_pend = 1'b1;
                dly_cnt  = delay_cfg;
            end
            if (dly_pend && dly_cnt > 0) dly_cnt--;
            if (dly_pend && dly_cnt == 0)
            begin
                dly_pend = 1'b0;
                advance_step();
                r.stp = 1'b1;
            end
            for (int k = 0; k < TRACKS; k++)
            begin
                if (trig_left[k] > 0)
                begin
                    r.trig[k] = 1'b1;
                    trig_left[k]--;
                end
                if (inv_left[k] > 0)
                begin
                    r.inv[k] = 1'b1;
                    inv_left[k]--;
                end
            end
        end
        else
        begin
            if (op == OP_PAT)
            begin
                nib_mem[{pattern_index, track}]  = nibbles;
                len_mem[{pattern_index, track}]  = length;
                wild_mem[{pattern_index, track}] = wild_mask;
            end
            else if (op == OP_TRACK)
            begin
                mprob[track]   = main_prob;
                iprob[track]   = inv_prob;
                en_bits[track] = enable;
            end
            for (int k = 0; k < TRACKS; k++)
            begin
                r.trig[k] = trig_left[k] > 0;
                r.inv[k]  = inv_left[k] > 0;
            end
        end
        r.gate = gates;
        return r;
    endfunction

    initial
    begin
        delay_cfg  = 4'd0;
        pulse_cfg  = PULSE_RESET;
        lfsr       = SEED_RESET;
        position   = '0;
        cur_pat    = '0;
        dly_cnt    = '0;
        dly_pend   = 1'b0;
        gates      = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            len_mem[i]  = '0;
            nib_mem[i]  = '0;
            wild_mem[i] = '0;
        end
        for (int k = 0; k < TRACKS; k++)
        begin
            mprob[k]     = 10'd256;
            iprob[k]     = 9'd256;
            en_bits[k]   = 1'b1;
            trig_left[k] = '0;
            inv_left[k]  = '0;
        end
    end

    always @(posedge clk)
    begin
        seq_out_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DELAY: delay_cfg = cfg_data[3:0];
                    CFG_PULSE: pulse_cfg = cfg_data[15:0];
                    CFG_SEED:  lfsr = cfg_data == 0 ? 32'd1 : cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (trig_mask !== want.trig)
                    begin
                        $error("trig_mask exp %h got %h", want.trig, trig_mask);
                        fail_count++;
                    end
                    if (gate_mask !== want.gate)
                    begin
                        $error("gate_mask exp %h got %h", want.gate, gate_mask);
                        fail_count++;
                    end
                    if (inv_trig_mask !== want.inv)
                    begin
                        $error("inv_trig_mask exp %h got %h", want.inv, inv_trig_mask);
                        fail_count++;
                    end
                    if (stepped !== want.stp)
                    begin
                        $error("stepped exp %b got %b", want.stp, stepped);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_q.insert(expected_q.size(), predict_transfer());
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== dv/tb_hex_pattern_trigger_sequencer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hex_pattern_trigger_sequencer_core
// Drives pattern writes, track settings, no-op items and clock ticks into
// the sequencer under random idling and a long output hold-off, over several
// register settings; the checker predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_hex_pattern_trigger_sequencer_core;
    import hpts_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic        clock_edge;
    logic        reset_edge;
    logic [6:0]  pattern_select;
    logic [3:0]  track;
    logic [6:0]  pattern_index;
    logic [63:0] nibbles;
    logic [4:0]  length;
    logic [15:0] wild_mask;
    logic [9:0]  main_prob;
    logic [8:0]  inv_prob;
    logic        enable;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] trig_mask;
    logic [15:0] gate_mask;
    logic [15:0] inv_trig_mask;
    logic        stepped;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off;
    int          quiet_cycles;
    logic [6:0]  play_pat;

    hex_pattern_trigger_sequencer_core DUT (.*);
    hpts_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= $urandom_range(99) < recv_idle_pct;
    end

    task automatic send_item(input op_t o, input logic ce, input logic re,
                             input logic [6:0] sel, input logic [3:0] trk,
                             input logic [6:0] pat, input logic [63:0] nib,
                             input logic [4:0] len, input logic [15:0] wild,
                             input logic [9:0] mp, input logic [8:0] ip,
                             input logic en);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        clock_edge     <= ce;
        reset_edge     <= re;
        pattern_select <= sel;
        track          <= trk;
        pattern_index  <= pat;
        nibbles        <= nib;
        length         <= len;
        wild_mask      <= wild;
        main_prob      <= mp;
        inv_prob       <= ip;
        enable         <= en;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_slot(input logic [6:0] pat, input logic [3:0] trk,
                              input logic [63:0] nib, input logic [4:0] len,
                              input logic [15:0] wild);
        send_item(OP_PAT, 1'($urandom), 1'($urandom), 7'($urandom), trk, pat, nib,
                  len, wild, 10'($urandom), 9'($urandom), 1'($urandom));
    endtask

    task automatic set_track(input logic [3:0] trk, input logic [9:0] mp,
                             input logic [8:0] ip, input logic en);
        send_item(OP_TRACK, 1'($urandom), 1'($urandom), 7'($urandom), trk,
                  7'($urandom), {$urandom, $urandom}, 5'($urandom), 16'($urandom),
                  mp, ip, en);
    endtask

    task automatic tick(input logic ce, input logic re, input logic [6:0] sel);
        send_item(OP_TICK, ce, re, sel, 4'($urandom), 7'($urandom),
                  {$urandom, $urandom}, 5'($urandom), 16'($urandom), 10'($urandom),
                  9'($urandom), 1'($urandom));
    endtask

    task automatic drain_and_wait();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [9:0] rand_main();
        case ($urandom_range(5))
            0: return 10'd256;
            1: return 10'd0;
            2: return 10'($urandom_range(1023, 513));
            3: return 10'($urandom_range(512, 257));
            default: return 10'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [8:0] rand_inv();
        case ($urandom_range(3))
            0: return 9'd256;
            1: return 9'($urandom_range(511, 257));
            default: return 9'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [6:0] pick_pattern();
        logic [6:0] p;
        if ($urandom_range(9) == 0) return 7'($urandom);
        p = play_pat;
        if ($urandom_range(19) == 0) p = 7'($urandom_range(3));
        return p;
    endfunction

    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                write_slot(7'($urandom_range(3)), 4'($urandom), {$urandom, $urandom},
                           5'($urandom), 16'($urandom));
            else if (r < 13)
                set_track(4'($urandom), rand_main(), rand_inv(), $urandom_range(7) != 0);
            else if (r < 15)
                send_item(OP_NONE, 1'($urandom), 1'($urandom), 7'($urandom),
                          4'($urandom), 7'($urandom), {$urandom, $urandom},
                          5'($urandom), 16'($urandom), 10'($urandom),
                          9'($urandom), 1'($urandom));
            else
            begin
                play_pat = pick_pattern();
                tick($urandom_range(2) == 0, $urandom_range(15) == 0, play_pat);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_TICK;
        clock_edge     = 1'b0;
        reset_edge     = 1'b0;
        pattern_select = '0;
        track          = '0;
        pattern_index  = '0;
        nibbles        = '0;
        length         = '0;
        wild_mask      = '0;
        main_prob      = '0;
        inv_prob       = '0;
        enable         = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_DELAY;
        cfg_data       = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        play_pat       = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_PULSE, 32'd3);
        write_reg(CFG_DELAY, 32'd0);
        write_reg(CFG_SEED, 32'd0);

        // directed: edges of fields, every op, corner cases
        send_idle_pct = 25;
        recv_idle_pct = 81;
        tick(1'b1, 1'b0, 7'd0);
        write_slot(7'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 16'h0000);
        write_slot(7'd0, 4'd1, 64'hA5F0_0000_0000_0000, 5'd31, 16'hFFFF);
        write_slot(7'd0, 4'd15, 64'h8000_0000_0000_0000, 5'd1, 16'h0000);
        write_slot(7'd127, 4'd2, 64'h0123_4567_89AB_CDEF, 5'd16, 16'h8001);
        set_track(4'd1, 10'd1023, 9'd511, 1'b1);
        set_track(4'd0, 10'd0, 9'd0, 1'b1);
        set_track(4'd15, 10'd300, 9'd100, 1'b0);
        send_item(OP_NONE, 1'b1, 1'b1, 7'd127, 4'd15, 7'd127, '1, 5'd31, '1,
                  10'd1023, 9'd511, 1'b1);
        tick(1'b1, 1'b1, 7'd0);
        tick(1'b1, 1'b0, 7'd0);
        tick(1'b0, 1'b0, 7'd0);
        tick(1'b1, 1'b0, 7'd127);
        tick(1'b1, 1'b1, 7'd127);
        tick(1'b0, 1'b0, 7'd127);
        set_track(4'd0, 10'd256, 9'd256, 1'b1);
        tick(1'b1, 1'b0, 7'd0);
        tick(1'b1, 1'b0, 7'd5);
        play_pat = 7'd0;
        drain_and_wait();

        write_reg(CFG_DELAY, 32'd10);
        write_reg(CFG_PULSE, 32'd1);
        write_reg(CFG_SEED, 32'hFFFF_FFFF);
        random_phase(230);
        drain_and_wait();

        send_idle_pct = 81;
        recv_idle_pct = 25;
        write_reg(CFG_DELAY, 32'd2);
        write_reg(CFG_PULSE, 32'd65535);
        write_reg(CFG_SEED, $urandom);
        random_phase(230);
        drain_and_wait();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_DELAY, 32'd1);
        write_reg(CFG_PULSE, $urandom_range(40, 2));
        write_reg(CFG_SEED, $urandom);
        fork
            random_phase(230);
            begin
                repeat (50) @(negedge clk);
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
        join
        drain_and_wait();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
